>>> rtl/assert_macros.svh
// Assertion macros used by the RTL queue module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition never holds at a clock edge outside reset.
`define USHCP_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("never-condition violated");

// Check that a condition implies a consequence in the next cycle.
`define USHCP_ASSERT_NEXT(lbl, cond, conseq) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error("next-cycle implication violated");

`endif

>>> rtl/ushcp_pkg.sv
// Types, constants and a helper function for the UTF-8 hash colour picker.
package ushcp_pkg;

    localparam int SCALAR_W = 21;
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = 2;
    localparam int QCNT_W   = 3;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  colour_index;
        logic [23:0] fill_colour;
    } out_item_t;

    typedef struct packed {
        logic [SCALAR_W-1:0] scalar;
        logic                last;
    } scalar_op_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic [1:0] {
        BK_FOLD,
        BK_ABS,
        BK_MOD,
        BK_DONE
    } bk_state_t;

    localparam logic [23:0] COLOUR_TABLE [6] = '{
        24'hBF8056,
        24'h53A655,
        24'h5285CC,
        24'hAA60BF,
        24'hB89F53,
        24'h6D5AC7
    };

    function automatic logic [23:0] colour_pick(input logic [5:0] r);
        logic [5:0] v;
        v = r;
        if (v >= 6'd48) v = v - 6'd48;
        if (v >= 6'd24) v = v - 6'd24;
        if (v >= 6'd12) v = v - 6'd12;
        if (v >= 6'd6)  v = v - 6'd6;
        return COLOUR_TABLE[v[2:0]];
    endfunction

endpackage

>>> rtl/ushcp_front.sv
// Front end: accepts bytes, runs the lenient UTF-8 decoder, emits scalars.
module ushcp_front
    import ushcp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  in_item_t   byte_item,
    input  q_status_t  q_status,
    output logic       push,
    output scalar_op_t push_op
);

    logic       busy_reg, busy_next;
    logic [7:0] work_byte_reg, work_byte_next;
    logic       work_last_reg, work_last_next;
    logic [2:0] seq_len_reg, seq_len_next;
    logic [7:0] lead_reg, lead_next;
    logic [7:0] held_reg [2];
    logic [7:0] held_next [2];
    logic [1:0] nheld_reg, nheld_next;
    logic [1:0] fptr_reg, fptr_next;

    logic       cont;
    logic [2:0] needed;
    logic [2:0] nh1;
    logic       complete;
    logic       hold;
    logic       brk;
    logic [2:0] lead_len;
    logic       done;
    logic [1:0] fidx;
    logic [SCALAR_W-1:0] decoded;

    always_comb
    begin
        case (work_byte_reg) inside
            8'b110?????: lead_len = 3'd2;
            8'b1110????: lead_len = 3'd3;
            8'b11110???: lead_len = 3'd4;
            default:     lead_len = 3'd1;
        endcase
    end

    always_comb
    begin
        case (seq_len_reg)
            3'd2:    decoded = {10'd0, lead_reg[4:0], work_byte_reg[5:0]};
            3'd3:    decoded = {5'd0, lead_reg[3:0], held_reg[0][5:0], work_byte_reg[5:0]};
            default: decoded = {lead_reg[2:0], held_reg[0][5:0], held_reg[1][5:0],
                                work_byte_reg[5:0]};
        endcase
    end

    assign cont     = (work_byte_reg[7:6] == 2'b10);
    assign needed   = seq_len_reg - 3'd1;
    assign nh1      = {1'b0, nheld_reg} + 3'd1;
    assign complete = (seq_len_reg != 3'd0) && cont && (nh1 == needed);
    assign hold     = (seq_len_reg != 3'd0) && cont && !work_last_reg && (nh1 < needed);
    assign brk      = (seq_len_reg != 3'd0) && !complete && !hold;
    assign fidx     = fptr_reg - 2'd1;

    always_comb
    begin
        busy_next      = busy_reg;
        work_byte_next = work_byte_reg;
        work_last_next = work_last_reg;
        seq_len_next   = seq_len_reg;
        lead_next      = lead_reg;
        held_next      = held_reg;
        nheld_next     = nheld_reg;
        fptr_next      = fptr_reg;
        push           = 1'b0;
        push_op        = '{scalar: {13'd0, work_byte_reg}, last: work_last_reg};
        done           = 1'b0;

        if (busy_reg)
        begin
            if (brk)
            begin
                if (!q_status.full)
                begin
                    push = 1'b1;
                    if (fptr_reg == 2'd0)
                        push_op = '{scalar: {13'd0, lead_reg}, last: 1'b0};
                    else
                        push_op = '{scalar: {13'd0, held_reg[fidx[0]]}, last: 1'b0};
                    if (fptr_reg == nheld_reg)
                    begin
                        seq_len_next = 3'd0;
                        fptr_next    = 2'd0;
                    end
                    else
                    begin
                        fptr_next = fptr_reg + 2'd1;
                    end
                end
            end
            else if (complete)
            begin
                if (!q_status.full)
                begin
                    push         = 1'b1;
                    push_op      = '{scalar: decoded, last: work_last_reg};
                    seq_len_next = 3'd0;
                    done         = 1'b1;
                end
            end
            else if (hold)
            begin
                held_next[nheld_reg[0]] = work_byte_reg;
                nheld_next              = nheld_reg + 2'd1;
                done                    = 1'b1;
            end
            else if ((lead_len > 3'd1) && !work_last_reg)
            begin
                lead_next    = work_byte_reg;
                seq_len_next = lead_len;
                nheld_next   = 2'd0;
                fptr_next    = 2'd0;
                done         = 1'b1;
            end
            else if (!q_status.full)
            begin
                push = 1'b1;
                done = 1'b1;
            end
        end

        byte_stall = busy_reg && !done;

        if (byte_valid && !byte_stall)
        begin
            busy_next      = 1'b1;
            work_byte_next = byte_item.byte_value;
            work_last_next = byte_item.last_byte;
        end
        else if (done)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            seq_len_reg <= 3'd0;
            nheld_reg   <= 2'd0;
            fptr_reg    <= 2'd0;
        end
        else
        begin
            busy_reg    <= busy_next;
            seq_len_reg <= seq_len_next;
            nheld_reg   <= nheld_next;
            fptr_reg    <= fptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_byte_reg <= work_byte_next;
        work_last_reg <= work_last_next;
        lead_reg      <= lead_next;
        held_reg      <= held_next;
    end

endmodule

>>> rtl/ushcp_queue.sv
// Scalar queue between the decoder and the hash engine.
`include "assert_macros.svh"

module ushcp_queue
    import ushcp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  scalar_op_t push_op,
    input  logic       pop,
    output scalar_op_t pop_op,
    output q_status_t  q_status
);

    scalar_op_t        mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wptr_reg, wptr_next;
    logic [QPTR_W-1:0] rptr_reg, rptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign q_status.full  = (count_reg == QCNT_W'(QDEPTH));
    assign q_status.empty = (count_reg == '0);
    assign pop_op         = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next  = pop ? rptr_reg + 1'b1 : rptr_reg;
        count_next = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wptr_reg] <= push_op;
    end

    `USHCP_ASSERT_NEVER(a_no_push_full, push && q_status.full)
    `USHCP_ASSERT_NEVER(a_no_pop_empty, pop && q_status.empty)
    `USHCP_ASSERT_NEXT(a_push_only_fills, push && !pop, count_reg == $past(count_reg) + 1'b1)

endmodule

>>> rtl/ushcp_back.sv
// Back end: folds scalars into the hash, reduces it and drives the result.
module ushcp_back
    import ushcp_pkg::*;
#(
    parameter int PALETTE_SIZE = 6
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  q_status_t  q_status,
    input  scalar_op_t pop_op,
    output logic       pop,
    output logic       colour_valid,
    input  logic       colour_stall,
    output out_item_t  colour_item
);

    localparam int REM_W = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
    localparam int SUM_W = 14;

    function automatic logic [95:0] hex_weights();
        logic [95:0] w;
        int          r;
        w = '0;
        r = 1 % PALETTE_SIZE;
        for (int k = 0; k < 16; k++)
        begin
            w[6*k +: 6] = 6'(r);
            r = (r * 16) % PALETTE_SIZE;
        end
        return w;
    endfunction

    localparam logic [95:0] HEX_WEIGHTS = hex_weights();

    bk_state_t        state_reg, state_next;
    logic [63:0]      hash_reg, hash_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [1:0]       dig_reg, dig_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic             valid_reg, valid_next;
    out_item_t        item_reg, item_next;
    logic [5:0]       wt;
    logic [SUM_W-1:0] sum_part;
    logic [SUM_W-1:0] sum_hi;
    logic [SUM_W-1:0] sum_lo;

    always_comb
    begin
        sum_part = '0;
        wt       = '0;
        for (int k = 0; k < 8; k++)
        begin
            wt       = dig_reg[0] ? HEX_WEIGHTS[6*(k+8) +: 6] : HEX_WEIGHTS[6*k +: 6];
            sum_part = sum_part + SUM_W'(hash_reg[4*k +: 4]) * SUM_W'(wt);
        end
        sum_hi = sum_reg;
        for (int k = 7; k >= 4; k--)
        begin
            if (sum_hi >= SUM_W'(PALETTE_SIZE << k))
                sum_hi = sum_hi - SUM_W'(PALETTE_SIZE << k);
        end
        sum_lo = sum_reg;
        for (int k = 3; k >= 0; k--)
        begin
            if (sum_lo >= SUM_W'(PALETTE_SIZE << k))
                sum_lo = sum_lo - SUM_W'(PALETTE_SIZE << k);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        hash_next  = hash_reg;
        rem_next   = rem_reg;
        dig_next   = dig_reg;
        sum_next   = sum_reg;
        valid_next = valid_reg && colour_stall;
        item_next  = item_reg;
        pop        = 1'b0;

        case (state_reg)
            BK_FOLD:
            begin
                if (!q_status.empty)
                begin
                    pop       = 1'b1;
                    hash_next = (hash_reg << 5) - hash_reg + 64'(pop_op.scalar);
                    if (pop_op.last)
                        state_next = BK_ABS;
                end
            end
            BK_ABS:
            begin
                hash_next  = hash_reg[63] ? (~hash_reg + 64'd1) : hash_reg;
                rem_next   = '0;
                dig_next   = 2'd0;
                state_next = BK_MOD;
            end
            BK_MOD:
            begin
                dig_next = dig_reg + 2'd1;
                if (dig_reg == 2'd0)
                begin
                    sum_next  = sum_part;
                    hash_next = hash_reg >> 32;
                end
                else if (dig_reg == 2'd1)
                begin
                    sum_next = sum_reg + sum_part;
                end
                else if (dig_reg == 2'd2)
                begin
                    sum_next = sum_hi;
                end
                else
                begin
                    rem_next   = sum_lo[REM_W-1:0];
                    state_next = BK_DONE;
                end
            end
            BK_DONE:
            begin
                if (!valid_reg || !colour_stall)
                begin
                    valid_next             = 1'b1;
                    item_next.colour_index = 3'(rem_reg);
                    item_next.fill_colour  = colour_pick(6'(rem_reg));
                    hash_next              = '0;
                    state_next             = BK_FOLD;
                end
            end
            default:
            begin
                state_next = BK_FOLD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_FOLD;
            hash_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            hash_reg  <= hash_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dig_reg  <= dig_next;
        sum_reg  <= sum_next;
        item_reg <= item_next;
    end

    assign colour_valid = valid_reg;
    assign colour_item  = item_reg;

endmodule

>>> rtl/utf8_scalar_hash_colour_pick.sv
// The decoder takes a new byte when idle or as it finishes the last; a broken sequence is
// first flushed byte by byte as scalars. The hash engine pops and folds scalars while the
// queue is not empty and no result is in work; the queue holds up to 4 scalars between the
// two. After the last scalar of a name the engine takes the absolute value, computes the
// modulo (two weighted digit sums, two reduction steps) and then loads the result.
// Reset clears the decoder, the queue, the hash and the result valid at once.
module utf8_scalar_hash_colour_pick
    import ushcp_pkg::*;
#(
    parameter int PALETTE_SIZE = 6
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      byte_valid,
    output logic      byte_stall,
    input  in_item_t  byte_item,
    output logic      colour_valid,
    input  logic      colour_stall,
    output out_item_t colour_item
);

    q_status_t  q_status;
    logic       push;
    scalar_op_t push_op;
    logic       pop;
    scalar_op_t pop_op;

    ushcp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .q_status   (q_status),
        .push       (push),
        .push_op    (push_op)
    );

    ushcp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_op  (push_op),
        .pop      (pop),
        .pop_op   (pop_op),
        .q_status (q_status)
    );

    ushcp_back #(
        .PALETTE_SIZE (PALETTE_SIZE)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_status     (q_status),
        .pop_op       (pop_op),
        .pop          (pop),
        .colour_valid (colour_valid),
        .colour_stall (colour_stall),
        .colour_item  (colour_item)
    );

endmodule
